>>> sv/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam logic [31:0] MAX_MSG_RESET = 32'd67108864;
	localparam logic [6:0]  CTRL_MAX_LEN  = 7'd125;
	localparam logic [6:0]  LEN7_EXT16    = 7'd126;
	localparam logic [6:0]  LEN7_EXT64    = 7'd127;
	localparam logic [7:0]  RSV_MASK      = 8'h70;

	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	typedef enum logic [2:0] {
		KIND_HEADER  = 3'd0,
		KIND_PAYLOAD = 3'd1,
		KIND_EMPTY   = 3'd2,
		KIND_PROTO   = 3'd3,
		KIND_TOO_BIG = 3'd4,
		KIND_IGNORED = 3'd5
	} kind_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       new_connection;
	} in_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [3:0] frame_opcode;
		logic       fin_bit;
		logic       frame_end;
	} out_item_t;

endpackage

>>> sv/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Frame parser state and per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module wsd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  wsd_pkg::in_item_t   item,
	input  logic [31:0]         max_message_bytes,
	output wsd_pkg::out_item_t  result
);
	import wsd_pkg::*;

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_EXT  = 3'd2,
		PH_MASK = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	phase_t      phase_q, ph_e, ph_n;
	logic [3:0]  opcode_q, op_e, op_n;
	logic        fin_q, fin_e, fin_n;
	logic [63:0] rem_q, rem_e, rem_n;
	logic [2:0]  cnt_q, cnt_e, cnt_n;
	logic [31:0] key_q, key_e, key_n;
	logic [1:0]  idx_q, idx_e, idx_n;
	logic        frag_q, frag_e, frag_n;
	logic [32:0] total_q, total_e, total_n;
	logic        closed_q, closed_e, closed_n;

	logic [7:0]  b;
	logic [6:0]  len7;
	logic [63:0] len_acc;
	logic [32:0] sum;
	logic        ctl_big, too_big, msg_big, known;
	logic [7:0]  key_byte;
	kind_t       kind;
	logic [7:0]  data;
	logic        fend;

	always_comb begin
		b    = item.rx_byte;
		len7 = b[6:0];

		if (item.new_connection) begin
			ph_e     = PH_HDR0;
			op_e     = 4'd0;
			fin_e    = 1'b0;
			rem_e    = 64'd0;
			cnt_e    = 3'd0;
			key_e    = 32'd0;
			idx_e    = 2'd0;
			frag_e   = 1'b0;
			total_e  = 33'd0;
			closed_e = 1'b0;
		end else begin
			ph_e     = phase_q;
			op_e     = opcode_q;
			fin_e    = fin_q;
			rem_e    = rem_q;
			cnt_e    = cnt_q;
			key_e    = key_q;
			idx_e    = idx_q;
			frag_e   = frag_q;
			total_e  = total_q;
			closed_e = closed_q;
		end

		ph_n     = ph_e;
		op_n     = op_e;
		fin_n    = fin_e;
		rem_n    = rem_e;
		cnt_n    = cnt_e;
		key_n    = key_e;
		idx_n    = idx_e;
		frag_n   = frag_e;
		total_n  = total_e;
		closed_n = closed_e;
		kind     = KIND_HEADER;
		data     = 8'd0;
		fend     = 1'b0;

		// length check shared by short and extended lengths
		len_acc = (ph_e == PH_HDR1) ? {57'd0, len7} : {rem_e[55:0], b};
		ctl_big = op_e[3] && (len_acc > {57'd0, CTRL_MAX_LEN});
		too_big = len_acc > {32'd0, max_message_bytes};
		sum     = total_e + {1'b0, len_acc[31:0]};
		msg_big = (op_e == OP_CONT) && (sum > {1'b0, max_message_bytes});

		known = (b[3:0] == OP_CONT) || (b[3:0] == OP_TEXT) || (b[3:0] == OP_BINARY) ||
			(b[3:0] == OP_CLOSE) || (b[3:0] == OP_PING) || (b[3:0] == OP_PONG);

		case (idx_e)
			2'd0:    key_byte = key_e[31:24];
			2'd1:    key_byte = key_e[23:16];
			2'd2:    key_byte = key_e[15:8];
			default: key_byte = key_e[7:0];
		endcase

		if (closed_e) begin
			kind = KIND_IGNORED;
		end else begin
			case (ph_e)
				PH_HDR0: begin
					fin_n = b[7];
					op_n  = b[3:0];
					if (((b & RSV_MASK) != 8'd0) || !known ||
						(b[3] && !b[7]) ||
						((b[3:0] == OP_CONT) && !frag_e) ||
						(((b[3:0] == OP_TEXT) || (b[3:0] == OP_BINARY)) && frag_e)) begin
						kind     = KIND_PROTO;
						closed_n = 1'b1;
						ph_n     = PH_HDR0;
					end else begin
						ph_n = PH_HDR1;
					end
				end
				PH_HDR1, PH_EXT: begin
					if ((ph_e == PH_HDR1) && !b[7]) begin
						kind     = KIND_PROTO;
						closed_n = 1'b1;
						ph_n     = PH_HDR0;
					end else if ((ph_e == PH_HDR1) &&
						((len7 == LEN7_EXT16) || (len7 == LEN7_EXT64))) begin
						rem_n = 64'd0;
						cnt_n = (len7 == LEN7_EXT16) ? 3'd1 : 3'd7;
						ph_n  = PH_EXT;
					end else if ((ph_e == PH_EXT) && (cnt_e != 3'd0)) begin
						rem_n = len_acc;
						cnt_n = cnt_e - 3'd1;
					end else begin
						rem_n = len_acc;
						if (len_acc[63] || ctl_big) begin
							kind     = KIND_PROTO;
							closed_n = 1'b1;
							ph_n     = PH_HDR0;
						end else if (too_big || msg_big) begin
							kind     = KIND_TOO_BIG;
							closed_n = 1'b1;
							ph_n     = PH_HDR0;
						end else begin
							if (((op_e == OP_TEXT) || (op_e == OP_BINARY)) && !fin_e) begin
								frag_n  = 1'b1;
								total_n = len_acc[32:0];
							end else if (op_e == OP_CONT) begin
								if (fin_e) begin
									frag_n  = 1'b0;
									total_n = 33'd0;
								end else begin
									total_n = sum;
								end
							end
							ph_n  = PH_MASK;
							cnt_n = 3'd3;
							key_n = 32'd0;
						end
					end
				end
				PH_MASK: begin
					key_n = {key_e[23:0], b};
					if (cnt_e == 3'd0) begin
						if (rem_e == 64'd0) begin
							kind = KIND_EMPTY;
							fend = 1'b1;
							ph_n = PH_HDR0;
							if (op_e == OP_CLOSE) begin
								closed_n = 1'b1;
							end
						end else begin
							ph_n  = PH_DATA;
							idx_n = 2'd0;
						end
					end else begin
						cnt_n = cnt_e - 3'd1;
					end
				end
				PH_DATA: begin
					kind  = KIND_PAYLOAD;
					data  = b ^ key_byte;
					idx_n = idx_e + 2'd1;
					rem_n = rem_e - 64'd1;
					if (rem_e == 64'd1) begin
						fend = 1'b1;
						ph_n = PH_HDR0;
						if (op_e == OP_CLOSE) begin
							closed_n = 1'b1;
						end
					end
				end
				default: begin
					ph_n = PH_HDR0;
				end
			endcase
		end

		result.kind         = kind;
		result.data_byte    = data;
		result.frame_opcode = op_n;
		result.fin_bit      = fin_n;
		result.frame_end    = fend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			opcode_q <= 4'd0;
			fin_q    <= 1'b0;
			rem_q    <= 64'd0;
			cnt_q    <= 3'd0;
			key_q    <= 32'd0;
			idx_q    <= 2'd0;
			frag_q   <= 1'b0;
			total_q  <= 33'd0;
			closed_q <= 1'b0;
		end else if (step) begin
			phase_q  <= ph_n;
			opcode_q <= op_n;
			fin_q    <= fin_n;
			rem_q    <= rem_n;
			cnt_q    <= cnt_n;
			key_q    <= key_n;
			idx_q    <= idx_n;
			frag_q   <= frag_n;
			total_q  <= total_n;
			closed_q <= closed_n;
		end
	end

endmodule

>>> sv/websocket_client_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_client_frame_deframer
// Client-to-server frame deframer: header parse, unmasking, error reporting.
// ----------------------------------------------------------------------------
// usage
//   item channel: one received byte per transaction, with new_connection
//   marking the first byte of a fresh connection (parser state is cleared
//   before that byte is parsed; max_message_bytes is kept)
//   result channel: exactly one result per input transaction, in order
//   config: cfg_we writes cfg_wdata into max_message_bytes; write only
//   while no result is pending
//   latency: result valid one cycle after the input transaction
//   throughput: one byte per cycle, set by the single-cycle parser update
//   feeding one output register
//   stall: item_stall rises when the output register is full and
//   result_stall is high; the held result stays stable until taken
//   reset: arst_n clears the parser and output valid and sets
//   max_message_bytes to 64 MiB
// ----------------------------------------------------------------------------
module websocket_client_frame_deframer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  wsd_pkg::in_item_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output wsd_pkg::out_item_t  result,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata
);
	import wsd_pkg::*;

	logic      [31:0] max_msg_q;
	logic             result_valid_q;
	out_item_t        result_q;
	out_item_t        parsed;
	logic             accept;

	assign item_stall   = result_valid_q && result_stall;
	assign accept       = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	wsd_parser u_parser (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (accept),
		.item              (item),
		.max_message_bytes (max_msg_q),
		.result            (parsed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_msg_q <= MAX_MSG_RESET;
		end else if (cfg_we) begin
			max_msg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= parsed;
		end
	end

`ifndef SYNTHESIS
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_valid)
		else $error("accepted transaction produced no result");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("input stalled with empty output register");

	a_end_only_on_data: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.frame_end) |->
		(result.kind == KIND_PAYLOAD || result.kind == KIND_EMPTY))
		else $error("frame end on a non-payload result");

	a_empty_has_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.kind == KIND_EMPTY) |-> result.frame_end)
		else $error("empty frame without frame end");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.kind != KIND_PAYLOAD) |-> (result.data_byte == 8'd0))
		else $error("data byte set on a non-payload result");
`endif

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives framed client byte streams through the deframer: well-formed
// connections with random payloads, masks and length encodings, broken
// frames, size-cap overruns and trailing noise, under several
// max_message_bytes settings. A per-byte predictor checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import wsd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LIVE_PER_PHASE = 250;
	localparam int NUM_PHASES     = 6;

	typedef enum logic [2:0] {
		P_HDR0,
		P_HDR1,
		P_EXT,
		P_MASK,
		P_DATA
	} parse_phase_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	in_item_t    item;
	logic        result_valid;
	logic        result_stall;
	out_item_t   result;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	// predictor state
	parse_phase_t pr_phase;
	logic [3:0]   pr_opcode;
	logic         pr_fin;
	logic [63:0]  pr_remaining;
	logic [2:0]   pr_count;
	logic [31:0]  pr_key;
	logic [1:0]   pr_key_idx;
	logic         pr_in_frag;
	logic [32:0]  pr_msg_total;
	logic         pr_closed;
	logic [31:0]  msg_cap;

	in_item_t    wire_bytes[$];
	out_item_t   deframed_queue[$];
	logic [7:0]  frame_bytes[$];
	out_item_t   want;
	logic        start_conn;
	int          bytes_queued;
	int          bytes_taken;
	int          live_bytes;
	int          mismatches;
	int          idle_cycles;
	int          gap_left;
	int          stall_left;
	int          idle_rate;
	bit          idle_on;
	bit          item_done;
	bit          progress;

	websocket_client_frame_deframer uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_parser();
		pr_phase     = P_HDR0;
		pr_opcode    = OP_CONT;
		pr_fin       = 1'b0;
		pr_remaining = '0;
		pr_count     = '0;
		pr_key       = '0;
		pr_key_idx   = '0;
		pr_in_frag   = 1'b0;
		pr_msg_total = '0;
		pr_closed    = 1'b0;
	endfunction

	function automatic kind_t fail_conn(kind_t k);
		pr_closed = 1'b1;
		pr_phase  = P_HDR0;
		return k;
	endfunction

	function automatic bit opcode_known(logic [3:0] op);
		return op <= OP_BINARY || (op >= OP_CLOSE && op <= OP_PONG);
	endfunction

	function automatic void end_frame();
		if (pr_opcode == OP_CLOSE)
			pr_closed = 1'b1;
		pr_phase = P_HDR0;
	endfunction

	function automatic kind_t check_length();
		logic [63:0] cap;
		cap = {32'b0, msg_cap};
		if (pr_remaining[63])
			return fail_conn(KIND_PROTO);
		if (pr_opcode >= OP_CLOSE && pr_remaining > 64'(CTRL_MAX_LEN))
			return fail_conn(KIND_PROTO);
		if (pr_remaining > cap)
			return fail_conn(KIND_TOO_BIG);
		if (pr_opcode == OP_CONT && {31'b0, pr_msg_total} + pr_remaining > cap)
			return fail_conn(KIND_TOO_BIG);
		if (pr_opcode == OP_TEXT || pr_opcode == OP_BINARY) begin
			if (!pr_fin) begin
				pr_in_frag   = 1'b1;
				pr_msg_total = pr_remaining[32:0];
			end
		end else if (pr_opcode == OP_CONT) begin
			pr_msg_total = pr_msg_total + pr_remaining[32:0];
			if (pr_fin) begin
				pr_in_frag   = 1'b0;
				pr_msg_total = '0;
			end
		end
		pr_phase = P_MASK;
		pr_count = 3'd3;
		pr_key   = '0;
		return KIND_HEADER;
	endfunction

	function automatic out_item_t deframe_byte(in_item_t it);
		out_item_t  r;
		logic [7:0] b;
		logic [6:0] len7;
		b           = it.rx_byte;
		r.kind      = KIND_HEADER;
		r.data_byte = '0;
		r.frame_end = 1'b0;
		if (it.new_connection)
			clear_parser();
		if (pr_closed) begin
			r.kind = KIND_IGNORED;
		end else begin
			case (pr_phase)
				P_HDR0: begin
					pr_fin    = b[7];
					pr_opcode = b[3:0];
					if ((b & RSV_MASK) != 8'h00 || !opcode_known(pr_opcode))
						r.kind = fail_conn(KIND_PROTO);
					else if (pr_opcode >= OP_CLOSE && !pr_fin)
						r.kind = fail_conn(KIND_PROTO);
					else if (pr_opcode == OP_CONT && !pr_in_frag)
						r.kind = fail_conn(KIND_PROTO);
					else if ((pr_opcode == OP_TEXT || pr_opcode == OP_BINARY) && pr_in_frag)
						r.kind = fail_conn(KIND_PROTO);
					else
						pr_phase = P_HDR1;
				end
				P_HDR1: begin
					len7 = b[6:0];
					if (!b[7]) begin
						r.kind = fail_conn(KIND_PROTO);
					end else if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
						pr_remaining = '0;
						pr_count     = (len7 == LEN7_EXT16) ? 3'd1 : 3'd7;
						pr_phase     = P_EXT;
					end else begin
						pr_remaining = 64'(len7);
						r.kind       = check_length();
					end
				end
				P_EXT: begin
					pr_remaining = {pr_remaining[55:0], b};
					if (pr_count == 3'd0)
						r.kind = check_length();
					else
						pr_count = pr_count - 3'd1;
				end
				P_MASK: begin
					pr_key = {pr_key[23:0], b};
					if (pr_count == 3'd0) begin
						if (pr_remaining == 64'd0) begin
							r.kind      = KIND_EMPTY;
							r.frame_end = 1'b1;
							end_frame();
						end else begin
							pr_phase   = P_DATA;
							pr_key_idx = '0;
						end
					end else begin
						pr_count = pr_count - 3'd1;
					end
				end
				P_DATA: begin
					r.data_byte  = b ^ pr_key[8 * (3 - int'(pr_key_idx)) +: 8];
					r.kind       = KIND_PAYLOAD;
					pr_key_idx   = pr_key_idx + 2'd1;
					pr_remaining = pr_remaining - 64'd1;
					if (pr_remaining == 64'd0) begin
						r.frame_end = 1'b1;
						end_frame();
					end
				end
				default: pr_phase = P_HDR0;
			endcase
		end
		r.frame_opcode = pr_opcode;
		r.fin_bit      = pr_fin;
		return r;
	endfunction

	function automatic void push_wire(logic [7:0] b, bit live);
		in_item_t it;
		it.rx_byte        = b;
		it.new_connection = start_conn;
		start_conn        = 1'b0;
		wire_bytes.push_back(it);
		bytes_queued++;
		if (live)
			live_bytes++;
	endfunction

	function automatic void flush_frame(bit live);
		foreach (frame_bytes[i])
			push_wire(frame_bytes[i], live);
		frame_bytes.delete();
	endfunction

	function automatic void add_junk();
		int n;
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++)
			push_wire(8'($urandom), 1'b0);
	endfunction

	function automatic void add_header(logic fin, logic [3:0] op, logic [63:0] len);
		int sel;
		sel = $urandom_range(0, 7);
		frame_bytes.push_back({fin, 3'b000, op});
		if (len > 64'd65535 || sel == 7) begin
			frame_bytes.push_back({1'b1, LEN7_EXT64});
			for (int i = 7; i >= 0; i--)
				frame_bytes.push_back(len[8 * i +: 8]);
		end else if (len > 64'(CTRL_MAX_LEN) || sel == 6) begin
			frame_bytes.push_back({1'b1, LEN7_EXT16});
			frame_bytes.push_back(len[15:8]);
			frame_bytes.push_back(len[7:0]);
		end else begin
			frame_bytes.push_back({1'b1, len[6:0]});
		end
	endfunction

	function automatic logic [63:0] pick_length(logic [3:0] op);
		int r;
		r = $urandom_range(0, 39);
		if (op >= OP_CLOSE)
			return (r == 0) ? 64'(CTRL_MAX_LEN) : 64'($urandom_range(0, 6));
		if (r == 0)
			return {32'b0, msg_cap} + 64'($urandom_range(1, 3));
		if (r < 4)
			return 64'($urandom_range(100, 300));
		return 64'($urandom_range(0, 12));
	endfunction

	function automatic void add_fault(logic in_frag);
		int         pick;
		logic [15:0] len16;
		case ($urandom_range(0, 7))
			0: frame_bytes.push_back({1'b1, 3'($urandom_range(1, 7)), OP_TEXT});
			1: begin
				pick = $urandom_range(0, 9);
				frame_bytes.push_back({1'($urandom), 3'b000,
					(pick < 5) ? 4'(3 + pick) : 4'(6 + pick)});
			end
			2: frame_bytes.push_back({1'b0, 3'b000,
				$urandom_range(0, 1) ? OP_CLOSE : OP_PING});
			3: begin
				if (in_frag)
					frame_bytes.push_back({1'($urandom), 3'b000, OP_BINARY});
				else
					frame_bytes.push_back({1'($urandom), 3'b000, OP_CONT});
			end
			4: begin
				frame_bytes.push_back({1'b1, 3'b000, OP_PING});
				frame_bytes.push_back({1'b0, 7'($urandom)});
			end
			5: begin
				frame_bytes.push_back({1'b1, 3'b000, OP_PING});
				frame_bytes.push_back({1'b1, LEN7_EXT64});
				frame_bytes.push_back(8'h80 | 8'($urandom));
				for (int i = 0; i < 7; i++)
					frame_bytes.push_back(8'($urandom));
			end
			6: begin
				len16 = 16'($urandom_range(126, 65535));
				frame_bytes.push_back({1'b1, 3'b000, OP_PONG});
				frame_bytes.push_back({1'b1, LEN7_EXT16});
				frame_bytes.push_back(len16[15:8]);
				frame_bytes.push_back(len16[7:0]);
			end
			default: begin
				pick = $urandom_range(1, 6);
				for (int i = 0; i < pick; i++)
					frame_bytes.push_back(8'($urandom));
			end
		endcase
	endfunction

	function automatic void gen_connection();
		logic        in_frag;
		logic [63:0] msg_sum;
		logic [63:0] len;
		logic [3:0]  op;
		logic        fin;
		int          n_frames;
		int          pick;
		int          keep;
		in_frag    = 1'b0;
		msg_sum    = '0;
		start_conn = ($urandom_range(0, 15) != 0);
		n_frames   = $urandom_range(1, 8);
		for (int f = 0; f < n_frames; f++) begin
			frame_bytes.delete();
			pick = $urandom_range(0, 99);
			if (pick < 7) begin
				add_fault(in_frag);
				flush_frame(1'b1);
				add_junk();
				return;
			end
			if (pick < 12)
				op = OP_CLOSE;
			else if (pick < 22)
				op = $urandom_range(0, 1) ? OP_PING : OP_PONG;
			else if (in_frag)
				op = OP_CONT;
			else
				op = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
			fin = (op >= OP_CLOSE) ? 1'b1 : 1'($urandom);
			len = pick_length(op);
			add_header(fin, op, len);
			if (len > {32'b0, msg_cap} ||
					(op == OP_CONT && msg_sum + len > {32'b0, msg_cap})) begin
				flush_frame(1'b1);
				add_junk();
				return;
			end
			for (int i = 0; i < 4; i++)
				frame_bytes.push_back(8'($urandom));
			for (longint i = 0; i < longint'(len); i++)
				frame_bytes.push_back(8'($urandom));
			if (op == OP_TEXT || op == OP_BINARY) begin
				if (!fin) begin
					in_frag = 1'b1;
					msg_sum = len;
				end
			end else if (op == OP_CONT) begin
				msg_sum = msg_sum + len;
				if (fin) begin
					in_frag = 1'b0;
					msg_sum = '0;
				end
			end
			// connection dropped mid-frame
			if ($urandom_range(0, 29) == 0) begin
				keep = $urandom_range(1, frame_bytes.size() - 1);
				while (frame_bytes.size() > keep)
					frame_bytes.delete(frame_bytes.size() - 1);
				flush_frame(1'b1);
				return;
			end
			flush_frame(1'b1);
			if (op == OP_CLOSE) begin
				add_junk();
				return;
			end
		end
	endfunction

	function automatic void push_directed(logic [7:0] b, logic nc);
		start_conn = nc;
		push_wire(b, 1'b1);
	endfunction

	function automatic void load_directed();
		// text frame, two bytes, alternating key
		push_directed(8'h81, 1'b0);
		push_directed(8'h82, 1'b0);
		push_directed(8'hFF, 1'b0);
		push_directed(8'h00, 1'b0);
		push_directed(8'hFF, 1'b0);
		push_directed(8'h00, 1'b0);
		push_directed(8'h00, 1'b0);
		push_directed(8'hFF, 1'b0);
		// empty close, then a byte after close
		push_directed({1'b1, 3'b000, OP_CLOSE}, 1'b0);
		push_directed(8'h80, 1'b0);
		for (int i = 0; i < 4; i++)
			push_directed(8'h00, 1'b0);
		push_directed(8'hFF, 1'b0);
		// rsv set, stray continuation, unfinished ping, unknown opcode
		push_directed(8'hF1, 1'b1);
		push_directed({1'b1, 3'b000, OP_CONT}, 1'b1);
		push_directed({1'b0, 3'b000, OP_PING}, 1'b1);
		push_directed(8'h8F, 1'b1);
		// unmasked frame
		push_directed({1'b1, 3'b000, OP_TEXT}, 1'b1);
		push_directed(8'h7F, 1'b0);
	endfunction

	task automatic wait_until_drained();
		while (bytes_taken != bytes_queued || deframed_queue.size() != 0)
			@(negedge clk);
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_done) begin
			item_done = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (wire_bytes.size() != 0) begin
				item       <= wire_bytes.pop_front();
				item_valid <= 1'b1;
				if (idle_on && idle_rate != 0 && $urandom_range(1, 8 * idle_rate) == 1)
					gap_left = $urandom_range(1, 19);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver stall
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (idle_on && idle_rate != 0 && $urandom_range(1, 8 * idle_rate) == 1) begin
			stall_left = $urandom_range(0, 18);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// monitor and predictor
	always @(posedge clk) begin
		if (arst_n) begin
			progress = 1'b0;
			if (result_valid && !result_stall) begin
				progress = 1'b1;
				if (deframed_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: kind %0d data %02h op %0h fin %0b end %0b",
							result.kind, result.data_byte, result.frame_opcode,
							result.fin_bit, result.frame_end);
				end else begin
					want = deframed_queue.pop_front();
					if (result.kind !== want.kind || result.data_byte !== want.data_byte ||
							result.frame_opcode !== want.frame_opcode ||
							result.fin_bit !== want.fin_bit ||
							result.frame_end !== want.frame_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected kind %0d data %02h op %0h fin %0b ",
								"end %0b, got kind %0d data %02h op %0h fin %0b end %0b"},
								want.kind, want.data_byte, want.frame_opcode, want.fin_bit,
								want.frame_end, result.kind, result.data_byte,
								result.frame_opcode, result.fin_bit, result.frame_end);
					end
				end
			end
			if (cfg_we)
				msg_cap = cfg_wdata;
			if (item_valid && !item_stall) begin
				progress = 1'b1;
				deframed_queue.push_back(deframe_byte(item));
				bytes_taken++;
				item_done = 1'b1;
			end
			if ($urandom_range(0, 99) == 0)
				idle_rate = $urandom_range(0, 3);
			if (progress)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("websocket_client_frame_deframer verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] cap_plan[NUM_PHASES];
		int          target;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		result_stall = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		start_conn   = 1'b0;
		bytes_queued = 0;
		bytes_taken  = 0;
		live_bytes   = 0;
		mismatches   = 0;
		idle_cycles  = 0;
		gap_left     = 0;
		stall_left   = 0;
		idle_rate    = 2;
		idle_on      = 1'b1;
		item_done    = 1'b0;
		msg_cap      = MAX_MSG_RESET;
		clear_parser();
		cap_plan[0] = MAX_MSG_RESET;
		cap_plan[1] = 32'd0;
		cap_plan[2] = 32'd20;
		cap_plan[3] = 32'hFFFF_FFFF;
		cap_plan[4] = $urandom;
		cap_plan[5] = 32'd150;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				wait_until_drained();
				@(negedge clk);
				cfg_we    <= 1'b1;
				cfg_wdata <= cap_plan[ph];
				@(negedge clk);
				cfg_we <= 1'b0;
				@(posedge clk);
			end
			if (ph == NUM_PHASES - 1)
				idle_on = 1'b0;
			if (ph == 0)
				load_directed();
			target = live_bytes + LIVE_PER_PHASE;
			while (live_bytes < target)
				gen_connection();
		end
		wait_until_drained();
		repeat (4) @(negedge clk);
		if (mismatches == 0)
			$display("websocket_client_frame_deframer verification clean");
		else
			$display("websocket_client_frame_deframer verification failed");
		$finish;
	end

endmodule

>>> files.f
sv/wsd_pkg.sv
sv/wsd_parser.sv
sv/websocket_client_frame_deframer.sv
sim/testbench.sv
